// ----- rtl/gcbs_pkg.sv -----
// Shared types and constants of the grid cell bucket store.
package gcbs_pkg;

  localparam int MAX_SIDE        = 16;
  localparam int POOL_BLOCKS     = 8192;
  localparam int SLOTS_PER_BLOCK = 7;
  localparam int MAX_READ_BLOCKS = 64;

  localparam int CELL_W = 4;
  localparam int SIDE_W = 5;
  localparam int ID_W   = 24;
  localparam int BLK_W  = $clog2(POOL_BLOCKS);
  localparam int HDR_W  = BLK_W + 1;
  localparam int CNT_W  = 3;
  localparam int RDN_W  = $clog2(MAX_READ_BLOCKS);
  localparam int ROW_W  = HDR_W + SLOTS_PER_BLOCK * ID_W;
  localparam int FIRST_OVF = MAX_SIDE * MAX_SIDE * MAX_SIDE;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  typedef struct packed {
    logic              cmd;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [CELL_W-1:0] cell_z;
    logic [ID_W-1:0]   data_id;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] id_count;
    logic [ID_W-1:0]  id_slot0;
    logic [ID_W-1:0]  id_slot1;
    logic [ID_W-1:0]  id_slot2;
    logic [ID_W-1:0]  id_slot3;
    logic [ID_W-1:0]  id_slot4;
    logic [ID_W-1:0]  id_slot5;
    logic [ID_W-1:0]  id_slot6;
    logic             last;
  } out_t;

  // Request from the controller to the block memory
  typedef struct packed {
    logic             we;
    logic [BLK_W-1:0] waddr;
    logic [ROW_W-1:0] wdata;
    logic             re;
    logic [BLK_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- rtl/gcbs_ram.sv -----
// Generic simple dual-port RAM with registered read.
module gcbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/gcbs_ctrl.sv -----
// Sequencer: cell index, chain walk, read-modify-write and result register.
module gcbs_ctrl import gcbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIDE_W-1:0] grid_side,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  output mem_req_t          mem_req,
  input  logic [ROW_W-1:0]  mem_rdata
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_IDX   = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_RD    = 7'b0010000,
    S_EVAL  = 7'b0100000,
    S_LINK  = 7'b1000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [BLK_W-1:0]         clr_r, clr_nxt;
  logic [2*CELL_W:0]        t_r, t_nxt;
  logic [BLK_W-1:0]         blk_r, blk_nxt;
  in_t                      req_r, req_nxt;
  logic [HDR_W-1:0]         free_r, free_nxt;
  logic [RDN_W-1:0]         n_r, n_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_t                     out_r, out_nxt;

  logic                     out_free;
  logic                     bad;
  logic [HDR_W+SIDE_W-1:0]  blk_calc;
  logic [HDR_W-1:0]         hdr;
  logic [CNT_W-1:0]         cnt;
  logic [ID_W-1:0]          slot [SLOTS_PER_BLOCK];
  logic [ID_W-1:0]          oslot [SLOTS_PER_BLOCK];
  logic [ROW_W-1:0]         app_row;

  assign out_free = !out_valid_r || out_ready;
  assign bad = ({1'b0, req_r.cell_x} >= grid_side) || ({1'b0, req_r.cell_y} >= grid_side) ||
               ({1'b0, req_r.cell_z} >= grid_side);
  assign blk_calc = (HDR_W+SIDE_W)'(t_r) * (HDR_W+SIDE_W)'(grid_side)
                    + (HDR_W+SIDE_W)'(req_r.cell_z);
  assign hdr = mem_rdata[ROW_W-1 -: HDR_W];
  assign cnt = (hdr <= HDR_W'(SLOTS_PER_BLOCK)) ? hdr[CNT_W-1:0] : CNT_W'(SLOTS_PER_BLOCK);

  always_comb begin
    for (int s = 0; s < SLOTS_PER_BLOCK; s++) begin
      slot[s]  = mem_rdata[s*ID_W +: ID_W];
      oslot[s] = (s < int'(cnt)) ? slot[s] : '0;
    end
    app_row = mem_rdata;
    app_row[ROW_W-1 -: HDR_W] = hdr + HDR_W'(1);
    for (int s = 0; s < SLOTS_PER_BLOCK; s++) begin
      if (CNT_W'(s) == hdr[CNT_W-1:0]) begin
        app_row[s*ID_W +: ID_W] = req_r.data_id;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    t_nxt         = t_r;
    blk_nxt       = blk_r;
    req_nxt       = req_r;
    free_nxt      = free_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    mem_req       = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        clr_nxt       = clr_r + BLK_W'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_IDX;
        end
      end
      S_IDX: begin
        t_nxt = (2*CELL_W+1)'((2*CELL_W+SIDE_W)'(req_r.cell_x) * (2*CELL_W+SIDE_W)'(grid_side)
                + (2*CELL_W+SIDE_W)'(req_r.cell_y));
        n_nxt     = '0;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (out_free) begin
          if (bad) begin
            out_nxt        = '0;
            out_nxt.status = ST_RANGE;
            out_nxt.last   = 1'b1;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            blk_nxt       = blk_calc[BLK_W-1:0];
            mem_req.re    = 1'b1;
            mem_req.raddr = blk_calc[BLK_W-1:0];
            state_nxt     = S_EVAL;
          end
        end
      end
      S_RD: begin
        // hold the next block read until the result register can take it
        if (out_free) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = blk_r;
          state_nxt     = S_EVAL;
        end
      end
      S_EVAL: begin
        if (req_r.cmd == CMD_INSERT) begin
          out_nxt      = '0;
          out_nxt.last = 1'b1;
          if (hdr < HDR_W'(SLOTS_PER_BLOCK)) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = blk_r;
            mem_req.wdata = app_row;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else if (hdr == HDR_W'(SLOTS_PER_BLOCK)) begin
            if (free_r >= HDR_W'(POOL_BLOCKS)) begin
              out_nxt.status = ST_FULL;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = blk_r;
              mem_req.wdata = mem_rdata;
              mem_req.wdata[ROW_W-1 -: HDR_W] = free_r;
              state_nxt     = S_LINK;
            end
          end else if (hdr >= HDR_W'(POOL_BLOCKS)) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            blk_nxt   = hdr[BLK_W-1:0];
            state_nxt = S_RD;
          end
        end else begin
          out_nxt.status   = ST_OK;
          out_nxt.id_count = cnt;
          out_nxt.id_slot0 = oslot[0];
          out_nxt.id_slot1 = oslot[1];
          out_nxt.id_slot2 = oslot[2];
          out_nxt.id_slot3 = oslot[3];
          out_nxt.id_slot4 = oslot[4];
          out_nxt.id_slot5 = oslot[5];
          out_nxt.id_slot6 = oslot[6];
          out_nxt.last     = 1'b1;
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
          if (hdr > HDR_W'(SLOTS_PER_BLOCK)) begin
            if (&n_r) begin
              out_nxt.status = ST_TRUNC;
            end else if (hdr < HDR_W'(POOL_BLOCKS)) begin
              out_nxt.last = 1'b0;
              n_nxt        = n_r + RDN_W'(1);
              blk_nxt      = hdr[BLK_W-1:0];
              state_nxt    = S_RD;
            end
          end
        end
      end
      S_LINK: begin
        // start the fresh overflow block with the one id
        mem_req.we    = 1'b1;
        mem_req.waddr = free_r[BLK_W-1:0];
        mem_req.wdata = '0;
        mem_req.wdata[ROW_W-1 -: HDR_W] = HDR_W'(1);
        mem_req.wdata[ID_W-1:0] = req_r.data_id;
        free_nxt      = free_r + HDR_W'(1);
        out_nxt       = '0;
        out_nxt.last  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_r      <= HDR_W'(FIRST_OVF);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    t_r   <= t_nxt;
    blk_r <= blk_nxt;
    req_r <= req_nxt;
    n_r   <= n_nxt;
    out_r <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/grid_cell_bucket_store_top.sv -----
// Top level of the grid cell bucket store: side register, sequencer, block memory.
//
//  channel  ports                         dir  beat
//  in       in_valid/in_ready/in_data     in   one request: insert or read of a cell
//  out      out_valid/out_ready/out_data  out  one result; a read gives one per block
//  cfg      cfg_we/cfg_wdata              in   grid side, saturated to 16, no wait
//
// Insert: index, check, evaluate, then a read and evaluate per overflow block
// walked, plus a link step for a fresh block; each chain step is one read and one
// evaluate of the block memory. Read: the same steps to the first beat, then a read
// and evaluate per further block. After reset the block memory is swept, one row a
// cycle, before in_ready rises. A stalled out beat holds the walk at its next read.
module grid_cell_bucket_store_top import gcbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [SIDE_W-1:0] cfg_wdata
);

  logic [SIDE_W-1:0] side_r, side_nxt;
  mem_req_t          mem_req;
  logic [ROW_W-1:0]  mem_rdata;

  // saturate the side to the largest grid
  always_comb begin
    side_nxt = side_r;
    if (cfg_we) begin
      side_nxt = (cfg_wdata > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_W'(MAX_SIDE);
    end else begin
      side_r <= side_nxt;
    end
  end

  gcbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .grid_side (side_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // one row per block: header above seven id slots
  gcbs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (POOL_BLOCKS)
  ) u_block_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule
